/* hdl/vrt_pkg.sv */
package vrt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_VOX_DEF   = 64;

  // register indexes
  localparam logic [1:0] REG_EDGE  = 2'd0;
  localparam logic [1:0] REG_GAP   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  // setup sequence bounds
  localparam logic [4:0] SQR_LAST   = 5'd2;   // products 0..2: squares
  localparam logic [4:0] PROD_FIRST = 5'd3;   // products 3..18: walk terms
  localparam logic [4:0] PROD_LAST  = 5'd18;
  localparam logic [4:0] DIV_LAST   = 5'd5;   // dividends: o x/y/z, hit x/y/z
  localparam logic [5:0] ROOT_LAST  = 6'd33;  // 34 root digits
  localparam logic [5:0] DIV_FIN    = 6'd32;  // load, 31 digit steps, fix-up

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_MUL, OP_STORE, OP_ROOT, OP_TEND,
    OP_DLOAD, OP_DITER, OP_DFIN, OP_CHECK, OP_PICK, OP_ADV
  } op_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_MID, EM_LAST, EM_EMPTY
  } emit_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] sel;
    emit_t      emit;
    logic       trunc;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit_eq;
    logic slot_free;
    logic adv_stop;
  } sts_t;

endpackage

/* hdl/vrt_ctrl.sv */
module vrt_ctrl import vrt_pkg::*; #(
  parameter int MAX_VOX = MAX_VOX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CW = $clog2(MAX_VOX + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_SQR   = 12'b000000000100,
    S_ROOT  = 12'b000000001000,
    S_TEND  = 12'b000000010000,
    S_GATE  = 12'b000000100000,
    S_DIV   = 12'b000001000000,
    S_MUL   = 12'b000010000000,
    S_CHECK = 12'b000100000000,
    S_PICK  = 12'b001000000000,
    S_ADV   = 12'b010000000000,
    S_LAST  = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [4:0]      sel_r, sel_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            ph_r, ph_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            trunc_r, trunc_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    count_nxt = count_r;
    trunc_nxt = trunc_r;
    cmd       = '{op: OP_NONE, sel: sel_r, emit: EM_NONE, trunc: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          count_nxt = '0;
          trunc_nxt = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        sel_nxt   = '0;
        ph_nxt    = 1'b0;
        state_nxt = S_SQR;
      end
      S_SQR, S_MUL: begin
        if (!ph_r) begin
          cmd.op = OP_MUL;
          ph_nxt = 1'b1;
        end else begin
          cmd.op = OP_STORE;
          ph_nxt = 1'b0;
          if (state_r == S_SQR && sel_r == SQR_LAST) begin
            cnt_nxt   = '0;
            state_nxt = S_ROOT;
          end else if (state_r == S_MUL && sel_r == PROD_LAST) begin
            state_nxt = S_CHECK;
          end else begin
            sel_nxt = sel_r + 5'd1;
          end
        end
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = S_TEND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_TEND: begin
        cmd.op    = OP_TEND;
        state_nxt = S_GATE;
      end
      S_GATE: begin
        sel_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = sts.empty ? S_LAST : S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          cmd.op  = OP_DLOAD;
          cnt_nxt = cnt_r + 6'd1;
        end else if (cnt_r == DIV_FIN) begin
          cmd.op  = OP_DFIN;
          cnt_nxt = '0;
          if (sel_r == DIV_LAST) begin
            sel_nxt   = PROD_FIRST;
            ph_nxt    = 1'b0;
            state_nxt = S_MUL;
          end else begin
            sel_nxt = sel_r + 5'd1;
          end
        end else begin
          cmd.op  = OP_DITER;
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_CHECK: begin
        if (sts.hit_eq) begin
          state_nxt = S_LAST;
        end else if (count_r == CW'(MAX_VOX)) begin
          trunc_nxt = 1'b1;
          state_nxt = S_LAST;
        end else if (count_r == '0 || sts.slot_free) begin
          cmd.op    = OP_CHECK;
          cmd.emit  = (count_r == '0) ? EM_NONE : EM_MID;
          count_nxt = count_r + CW'(1);
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.op    = OP_PICK;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if (sts.adv_stop) begin
          state_nxt = S_LAST;
        end else begin
          cmd.op    = OP_ADV;
          state_nxt = S_CHECK;
        end
      end
      S_LAST: begin
        if (sts.slot_free) begin
          cmd.emit  = (count_r == '0) ? EM_EMPTY : EM_LAST;
          cmd.trunc = trunc_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
      cnt_r   <= '0;
      ph_r    <= 1'b0;
      count_r <= '0;
      trunc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
      count_r <= count_nxt;
      trunc_r <= trunc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != EM_NONE |-> sts.slot_free) else $error("emit into full output");
  a_last_has_voxel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit == EM_LAST |-> count_r != '0) else $error("last voxel without voxel");
  a_empty_no_voxel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit == EM_EMPTY |-> count_r == '0) else $error("empty after voxels");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VOX)) else $error("voxel count past cap");
`endif

endmodule

/* hdl/vrt_dp.sv */
module vrt_dp import vrt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata,
  input  logic [191:0] in_tdata,
  output logic [95:0]  out_tdata,
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  cmd_t         cmd,
  output sts_t         sts
);

  localparam logic [24:0] MIN_EDGE  = 25'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);
  localparam logic [24:0] EDGE_RST  = 25'(64'd1 << FRAC_BITS);
  localparam logic [30:0] LIMIT_RST = 31'(64'd20 << FRAC_BITS);

  logic [24:0]        edge_r;
  logic signed [25:0] gap_r;
  logic [30:0]        limit_r;

  logic signed [31:0] o_r [3];
  logic signed [31:0] h_r [3];
  logic [31:0]        ad_r [3];
  logic [2:0]         pos_r, neg_r;
  logic [24:0]        e_r;

  logic [67:0]        sq_r;
  logic [33:0]        root_r;
  logic [35:0]        rrem_r;
  logic [30:0]        tend_r;
  logic               empty_r;

  logic               dneg_r;
  logic [30:0]        du_r, dq_r;
  logic [24:0]        drem_r;

  logic signed [31:0] cell_r [3];
  logic signed [31:0] hitc_r [3];
  logic [31:0]        n_r [3];
  logic [31:0]        pend_r [3];

  logic [65:0]        p_r;
  logic [63:0]        x_r [6];   // n0*ad1, n1*ad0, n0*ad2, n2*ad0, n1*ad2, n2*ad1
  logic [56:0]        i_r [3];   // e*ad per axis
  logic [65:0]        l_r [3];   // n*len per axis
  logic [58:0]        il_r;      // e*len
  logic [62:0]        rr_r [3];  // t_end*ad per axis
  logic [1:0]         ax_r;
  logic               noax_r;

  logic [95:0]        odata_r;
  logic [1:0]         ouser_r;
  logic               olast_r, ovalid_r;

  // multiplier operand select
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      5'd0:  begin mul_a = {2'b0, ad_r[0]}; mul_b = ad_r[0]; end
      5'd1:  begin mul_a = {2'b0, ad_r[1]}; mul_b = ad_r[1]; end
      5'd2:  begin mul_a = {2'b0, ad_r[2]}; mul_b = ad_r[2]; end
      5'd3:  begin mul_a = {2'b0, n_r[0]};  mul_b = ad_r[1]; end
      5'd4:  begin mul_a = {2'b0, n_r[1]};  mul_b = ad_r[0]; end
      5'd5:  begin mul_a = {2'b0, n_r[0]};  mul_b = ad_r[2]; end
      5'd6:  begin mul_a = {2'b0, n_r[2]};  mul_b = ad_r[0]; end
      5'd7:  begin mul_a = {2'b0, n_r[1]};  mul_b = ad_r[2]; end
      5'd8:  begin mul_a = {2'b0, n_r[2]};  mul_b = ad_r[1]; end
      5'd9:  begin mul_a = {9'b0, e_r};     mul_b = ad_r[0]; end
      5'd10: begin mul_a = {9'b0, e_r};     mul_b = ad_r[1]; end
      5'd11: begin mul_a = {9'b0, e_r};     mul_b = ad_r[2]; end
      5'd12: begin mul_a = root_r;          mul_b = n_r[0];  end
      5'd13: begin mul_a = root_r;          mul_b = n_r[1];  end
      5'd14: begin mul_a = root_r;          mul_b = n_r[2];  end
      5'd15: begin mul_a = root_r;          mul_b = {7'b0, e_r}; end
      5'd16: begin mul_a = {3'b0, tend_r};  mul_b = ad_r[0]; end
      5'd17: begin mul_a = {3'b0, tend_r};  mul_b = ad_r[1]; end
      5'd18: begin mul_a = {3'b0, tend_r};  mul_b = ad_r[2]; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // setup arithmetic
  logic signed [32:0] d [3];
  logic [35:0]        rtrial, rcur;
  logic signed [35:0] tt, tt_sat;
  logic signed [31:0] dvd;
  logic [25:0]        dtrial;
  logic               dge;
  logic signed [31:0] cval;
  logic [24:0]        rmd;
  logic [31:0]        nval;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d[a] = {h_r[a][31], h_r[a]} - {o_r[a][31], o_r[a]};
    end
    rcur   = {rrem_r[33:0], sq_r[67:66]};
    rtrial = {root_r, 2'b01};
    tt     = $signed({2'b00, root_r}) - $signed({{10{gap_r[25]}}, gap_r});
    tt_sat = (tt > $signed({5'b0, limit_r})) ? $signed({5'b0, limit_r}) : tt;
    case (cmd.sel)
      5'd0:    dvd = o_r[0];
      5'd1:    dvd = o_r[1];
      5'd2:    dvd = o_r[2];
      5'd3:    dvd = h_r[0];
      5'd4:    dvd = h_r[1];
      default: dvd = h_r[2];
    endcase
    dtrial = {drem_r, du_r[30]};
    dge    = dtrial >= {1'b0, e_r};
    cval   = dneg_r ? ~$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    rmd    = dneg_r ? (e_r - 25'd1 - drem_r) : drem_r;
    nval   = '0;
    case (cmd.sel)
      5'd0, 5'd1, 5'd2: begin
        if (pos_r[cmd.sel[1:0]]) begin
          nval = {7'b0, e_r - rmd};
        end else if (neg_r[cmd.sel[1:0]]) begin
          nval = {7'b0, rmd};
        end
      end
      default: ;
    endcase
  end

  // walk decisions
  logic [2:0] mov;
  logic       le01, le02, le12;
  logic [1:0] ax_sel;
  logic       hit_eq;
  logic       beyond;

  always_comb begin
    mov    = pos_r | neg_r;
    le01   = !mov[1] || (mov[0] && x_r[0] <= x_r[1]);
    le02   = !mov[2] || (mov[0] && x_r[2] <= x_r[3]);
    le12   = !mov[2] || (mov[1] && x_r[4] <= x_r[5]);
    ax_sel = (le01 && le02) ? 2'd0 : (le12 ? 2'd1 : 2'd2);
    hit_eq = (cell_r[0] == hitc_r[0]) && (cell_r[1] == hitc_r[1])
             && (cell_r[2] == hitc_r[2]);
    case (ax_r)
      2'd0:    beyond = l_r[0] > {3'b0, rr_r[0]};
      2'd1:    beyond = l_r[1] > {3'b0, rr_r[1]};
      default: beyond = l_r[2] > {3'b0, rr_r[2]};
    endcase
  end

  assign sts.empty     = empty_r;
  assign sts.hit_eq    = hit_eq;
  assign sts.slot_free = !ovalid_r || out_tready;
  assign sts.adv_stop  = noax_r || beyond;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r  <= EDGE_RST;
      gap_r   <= '0;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE:  edge_r  <= cfg_wdata[24:0];
        REG_GAP:   gap_r   <= $signed(cfg_wdata[25:0]);
        REG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    p_r <= prod;
    case (cmd.op)
      OP_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          o_r[a] <= $signed(in_tdata[32*a +: 32]);
          h_r[a] <= $signed(in_tdata[96 + 32*a +: 32]);
        end
      end
      OP_PREP: begin
        for (int a = 0; a < 3; a++) begin
          ad_r[a]  <= d[a][32] ? 32'(-d[a]) : d[a][31:0];
          pos_r[a] <= !d[a][32] && (d[a] != '0);
          neg_r[a] <= d[a][32];
        end
        e_r    <= (edge_r < MIN_EDGE) ? MIN_EDGE : edge_r;
        sq_r   <= '0;
        root_r <= '0;
        rrem_r <= '0;
      end
      OP_STORE: begin
        case (cmd.sel)
          5'd0, 5'd1, 5'd2: sq_r <= sq_r + {2'b0, p_r};
          5'd3:  x_r[0]  <= p_r[63:0];
          5'd4:  x_r[1]  <= p_r[63:0];
          5'd5:  x_r[2]  <= p_r[63:0];
          5'd6:  x_r[3]  <= p_r[63:0];
          5'd7:  x_r[4]  <= p_r[63:0];
          5'd8:  x_r[5]  <= p_r[63:0];
          5'd9:  i_r[0]  <= p_r[56:0];
          5'd10: i_r[1]  <= p_r[56:0];
          5'd11: i_r[2]  <= p_r[56:0];
          5'd12: l_r[0]  <= p_r;
          5'd13: l_r[1]  <= p_r;
          5'd14: l_r[2]  <= p_r;
          5'd15: il_r    <= p_r[58:0];
          5'd16: rr_r[0] <= p_r[62:0];
          5'd17: rr_r[1] <= p_r[62:0];
          5'd18: rr_r[2] <= p_r[62:0];
          default: ;
        endcase
      end
      OP_ROOT: begin
        sq_r <= {sq_r[65:0], 2'b00};
        if (rcur >= rtrial) begin
          rrem_r <= rcur - rtrial;
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          rrem_r <= rcur;
          root_r <= {root_r[32:0], 1'b0};
        end
      end
      OP_TEND: begin
        tend_r  <= tt_sat[30:0];
        empty_r <= (root_r == '0) || (tt_sat <= 36'sd0);
      end
      OP_DLOAD: begin
        dneg_r <= dvd[31];
        du_r   <= dvd[31] ? ~dvd[30:0] : dvd[30:0];
        drem_r <= '0;
        dq_r   <= '0;
      end
      OP_DITER: begin
        du_r   <= {du_r[29:0], 1'b0};
        dq_r   <= {dq_r[29:0], dge};
        drem_r <= dge ? 25'(dtrial - {1'b0, e_r}) : dtrial[24:0];
      end
      OP_DFIN: begin
        case (cmd.sel)
          5'd0: begin cell_r[0] <= cval; n_r[0] <= nval; end
          5'd1: begin cell_r[1] <= cval; n_r[1] <= nval; end
          5'd2: begin cell_r[2] <= cval; n_r[2] <= nval; end
          5'd3: hitc_r[0] <= cval;
          5'd4: hitc_r[1] <= cval;
          default: hitc_r[2] <= cval;
        endcase
      end
      OP_CHECK: begin
        for (int a = 0; a < 3; a++) begin
          pend_r[a] <= cell_r[a];
        end
      end
      OP_PICK: begin
        ax_r   <= ax_sel;
        noax_r <= !mov[ax_sel];
      end
      OP_ADV: begin
        case (ax_r)
          2'd0: begin
            x_r[0]    <= x_r[0] + {7'b0, i_r[1]};
            x_r[2]    <= x_r[2] + {7'b0, i_r[2]};
            l_r[0]    <= l_r[0] + {7'b0, il_r};
            cell_r[0] <= neg_r[0] ? cell_r[0] - 32'sd1 : cell_r[0] + 32'sd1;
          end
          2'd1: begin
            x_r[1]    <= x_r[1] + {7'b0, i_r[0]};
            x_r[4]    <= x_r[4] + {7'b0, i_r[2]};
            l_r[1]    <= l_r[1] + {7'b0, il_r};
            cell_r[1] <= neg_r[1] ? cell_r[1] - 32'sd1 : cell_r[1] + 32'sd1;
          end
          default: begin
            x_r[3]    <= x_r[3] + {7'b0, i_r[0]};
            x_r[5]    <= x_r[5] + {7'b0, i_r[1]};
            l_r[2]    <= l_r[2] + {7'b0, il_r};
            cell_r[2] <= neg_r[2] ? cell_r[2] - 32'sd1 : cell_r[2] + 32'sd1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      odata_r <= (cmd.emit == EM_EMPTY) ? '0 : {pend_r[2], pend_r[1], pend_r[0]};
      ouser_r <= {cmd.emit == EM_LAST && cmd.trunc, cmd.emit == EM_EMPTY};
      olast_r <= (cmd.emit == EM_LAST) || (cmd.emit == EM_EMPTY);
    end
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;
  assign out_tvalid = ovalid_r;

endmodule

/* hdl/voxel_ray_traversal_top.sv */
// Channel | Direction | Transaction
// in_     | slave     | one ray: sensor origin and hit point, Q16.16
// out_    | master    | one traversed voxel index, or one empty marker
// cfg_    | write     | voxel_edge (0), sensor_gap (1), ray_limit (2)
//
// One ray at a time. Setup after the ray is accepted: the deltas, the squares on
// the shared multiplier, the bit-serial root, t_end and the empty check, then, unless
// the ray is empty, six floor divisions by the voxel edge and the walk products.
// The walk then runs check, pick axis and advance for each voxel, up to 64,
// and finally hands over the last result.
// rst_n is synchronous, active low; it restores the register defaults.
// A full output register stalls the walk; in_tready is high only when idle.
module voxel_ray_traversal_top import vrt_pkg::*; #(
  parameter int FRAC_BITS          = FRAC_BITS_DEF,
  parameter int MAX_VOXELS_PER_RAY = MAX_VOX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, hit_x, hit_y, hit_z
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cell_x, cell_y, cell_z
  output logic [95:0]  out_tdata,
  // empty_ray, truncated
  output logic [1:0]   out_tuser,
  // last_of_ray
  output logic         out_tlast
);

  cmd_t cmd;
  sts_t sts;

  // sequence setup and walk; hold off new rays until the last result is in the output register
  vrt_ctrl #(
    .MAX_VOX (MAX_VOXELS_PER_RAY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, shared multiplier, root and divide steps, DDA state
  vrt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
